@@ src/morse_code_codec_core_defines.svh @@
// ----------------------------------------------------------------------------
// Morse codec assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_CODEC_CORE_DEFINES_SVH
`define MORSE_CODE_CODEC_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Morse codec package
// Payload types, character codes and the alphabet tables with their lookup.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int CYR_COUNT  = 45;
    localparam int LAT_COUNT  = 38;
    localparam int CODE_W     = 6;
    localparam int MARK_W     = CODE_W + 1;
    localparam int CNT_W      = 3;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_DIRECTION = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHABET  = 1'b1;

    localparam logic DIR_ENC   = 1'b0;
    localparam logic DIR_DEC   = 1'b1;
    localparam logic ALPHA_CYR = 1'b0;
    localparam logic ALPHA_LAT = 1'b1;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_NUL  = 8'h00;

    localparam logic [1:0] K_NL  = 2'd0;
    localparam logic [1:0] K_ENC = 2'd1;
    localparam logic [1:0] K_DEC = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       error;
    } t_out;

    typedef struct packed {
        logic       en;
        logic       dec;
        logic       alpha;
        logic [7:0] key;
    } t_rom_req;

    typedef struct packed {
        logic              hit;
        logic [7:0]        chr;
        logic [CNT_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_rom_word;

    typedef struct packed {
        logic [7:0]        head_byte;
        logic              head_err;
        logic [CNT_W-1:0]  cnt;
        logic [CODE_W-1:0] bits;
        logic              nl;
    } t_job;

    localparam logic [7:0] CYR_CHARS [CYR_COUNT] = '{
        8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hB8, 8'hE6, 8'hE7, 8'hE8, 8'hE9,
        8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF, 8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4,
        8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h2E,
        8'h20};

    // A leading one marks the code length; dashes are ones, the first symbol highest.
    localparam logic [MARK_W-1:0] CYR_MARKS [CYR_COUNT] = '{
        7'b0000101, 7'b0011000, 7'b0001011, 7'b0001110, 7'b0001100, 7'b0000010,
        7'b0000010, 7'b0010001, 7'b0011100, 7'b0000100, 7'b0010111, 7'b0001101,
        7'b0010100, 7'b0000111, 7'b0000110, 7'b0001111, 7'b0010110, 7'b0001010,
        7'b0001000, 7'b0000011, 7'b0001001, 7'b0010010, 7'b0010000, 7'b0011010,
        7'b0011110, 7'b0011111, 7'b0011101, 7'b0111011, 7'b0011011, 7'b0011001,
        7'b0100100, 7'b0010011, 7'b0010101, 7'b0101111, 7'b0100111, 7'b0100011,
        7'b0100001, 7'b0100000, 7'b0110000, 7'b0111000, 7'b0111100, 7'b0111110,
        7'b0111111, 7'b1000000, 7'b1111111};

    localparam logic [7:0] LAT_CHARS [LAT_COUNT] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B,
        8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76,
        8'h77, 8'h78, 8'h79, 8'h7A, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h30, 8'h2E, 8'h20};

    localparam logic [MARK_W-1:0] LAT_MARKS [LAT_COUNT] = '{
        7'b0000101, 7'b0011000, 7'b0011010, 7'b0001100, 7'b0000010, 7'b0010010,
        7'b0001110, 7'b0010000, 7'b0000100, 7'b0010111, 7'b0001101, 7'b0010100,
        7'b0000111, 7'b0000110, 7'b0001111, 7'b0010110, 7'b0011101, 7'b0001010,
        7'b0001000, 7'b0000011, 7'b0001001, 7'b0010001, 7'b0001011, 7'b0011001,
        7'b0011011, 7'b0011100, 7'b0101111, 7'b0100111, 7'b0100011, 7'b0100001,
        7'b0100000, 7'b0110000, 7'b0111000, 7'b0111100, 7'b0111110, 7'b0111111,
        7'b1111111, 7'b1000000};

    // Encoding looks a character up; decoding looks a marked code up.
    // The first match in table order wins.
    function automatic t_rom_word rom_lookup(input logic dec, input logic alpha,
                                             input logic [7:0] key);
        t_rom_word         w;
        logic [MARK_W-1:0] mk;
        logic              found;
        w     = '0;
        mk    = '0;
        found = 1'b0;
        if (alpha == ALPHA_LAT) begin
            for (int i = 0; i < LAT_COUNT; i++) begin
                if (!found && ((!dec && LAT_CHARS[i] == key) ||
                               (dec && {1'b0, LAT_MARKS[i]} == key))) begin
                    found = 1'b1;
                    mk    = LAT_MARKS[i];
                    w.chr = LAT_CHARS[i];
                end
            end
        end else begin
            for (int i = 0; i < CYR_COUNT; i++) begin
                if (!found && ((!dec && CYR_CHARS[i] == key) ||
                               (dec && {1'b0, CYR_MARKS[i]} == key))) begin
                    found = 1'b1;
                    mk    = CYR_MARKS[i];
                    w.chr = CYR_CHARS[i];
                end
            end
        end
        w.hit = found;
        for (int j = 0; j < MARK_W; j++) begin
            if (mk[j]) begin
                w.len = CNT_W'(j);
            end
        end
        w.bits = CODE_W'(mk[CODE_W-1:0] << (CNT_W'(CODE_W) - w.len));
        return w;
    endfunction

endpackage

@@ src/mcc_rom.sv @@
// ----------------------------------------------------------------------------
// Morse codec code ROM
// Synchronous ROM holding both alphabets in both directions, registered read.
// ----------------------------------------------------------------------------
module mcc_rom (
    input  logic               i_clk,
    input  mcc_pkg::t_rom_req  i_req,
    output mcc_pkg::t_rom_word o_q
);
    import mcc_pkg::*;

    t_rom_word r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_q <= rom_lookup(i_req.dec, i_req.alpha, i_req.key);
        end
    end

    assign o_q = r_q;

endmodule

@@ src/mcc_front.sv @@
// ----------------------------------------------------------------------------
// Morse codec front end
// Accepts input transfers, keeps the pending symbol and the error flag, issues
// ROM reads and turns each looked-up item into an output job.
// ----------------------------------------------------------------------------
`include "morse_code_codec_core_defines.svh"

module mcc_front #(
    parameter int MAX_CODE_LEN = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mcc_pkg::t_in       i_in_data,
    input  logic               i_direction,
    input  logic               i_alphabet,
    output mcc_pkg::t_rom_req  o_rom_req,
    input  mcc_pkg::t_rom_word i_rom_q,
    output logic               o_job_valid,
    output mcc_pkg::t_job      o_job,
    input  logic               i_job_ready
);
    import mcc_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    logic [MAX_CODE_LEN-1:0] r_pat, n_pat;
    logic [LEN_W-1:0]        r_len, n_len;
    logic                    r_inv, n_inv;
    logic                    r_failed, n_failed;
    logic                    r_s1_valid;
    logic [1:0]              r_s1_kind;
    logic                    r_s1_bad;
    logic                    r_s1_nl;
    logic                    r_s1_setfail;

    logic       s1_err;
    logic       s1_move;
    logic       fail_eff;
    logic       acc;
    logic       pend_any;
    logic [8:0] mark9;
    logic       ld;
    logic [1:0] ld_kind;
    logic       ld_nl;
    logic       ld_setfail;
    logic [7:0] rom_key;
    logic       rom_dec;
    t_job       job;
    t_in        din;

    assign din = i_in_data;

    always_comb begin
        s1_err = 1'b0;
        job    = '0;
        unique case (r_s1_kind)
            K_NL: begin
                job.head_byte = CH_LF;
            end
            K_ENC: begin
                s1_err = !i_rom_q.hit;
                if (i_rom_q.hit) begin
                    job.head_byte = CH_SP;
                    job.cnt       = i_rom_q.len;
                    job.bits      = i_rom_q.bits;
                end else begin
                    job.head_byte = CH_NUL;
                    job.head_err  = 1'b1;
                end
            end
            K_DEC: begin
                s1_err = r_s1_bad || !i_rom_q.hit;
                if (!s1_err) begin
                    job.head_byte = i_rom_q.chr;
                    job.nl        = r_s1_nl;
                end else begin
                    job.head_byte = CH_NUL;
                    job.head_err  = 1'b1;
                end
            end
            default: begin
                s1_err = 1'b0;
            end
        endcase
    end

    assign s1_move    = r_s1_valid && i_job_ready;
    assign fail_eff   = r_failed || (r_s1_valid && s1_err && r_s1_setfail);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign acc        = i_in_valid && o_in_ready;
    assign pend_any   = (r_len != '0) || r_inv;
    assign mark9      = (9'd1 << r_len) | 9'(r_pat);

    always_comb begin
        n_pat      = r_pat;
        n_len      = r_len;
        n_inv      = r_inv;
        n_failed   = r_failed;
        ld         = 1'b0;
        ld_kind    = K_NL;
        ld_nl      = 1'b0;
        ld_setfail = 1'b1;
        rom_dec    = 1'b0;
        rom_key    = din.in_byte;
        if (s1_move && s1_err && r_s1_setfail) begin
            n_failed = 1'b1;
        end
        if (acc) begin
            priority if (din.end_of_text) begin
                if ((i_direction == DIR_DEC) && !fail_eff && pend_any) begin
                    ld         = 1'b1;
                    ld_kind    = K_DEC;
                    ld_setfail = 1'b0;
                end
                n_pat    = '0;
                n_len    = '0;
                n_inv    = 1'b0;
                n_failed = 1'b0;
            end else if (fail_eff) begin
                n_pat = '0;
                n_len = '0;
                n_inv = 1'b0;
            end else if (i_direction == DIR_ENC) begin
                ld      = 1'b1;
                ld_kind = (din.in_byte == CH_LF) ? K_NL : K_ENC;
            end else if (din.in_byte == CH_SP) begin
                if (pend_any) begin
                    ld      = 1'b1;
                    ld_kind = K_DEC;
                    n_pat   = '0;
                    n_len   = '0;
                    n_inv   = 1'b0;
                end
            end else if (din.in_byte == CH_LF) begin
                ld = 1'b1;
                if (pend_any) begin
                    ld_kind = K_DEC;
                    ld_nl   = 1'b1;
                    n_pat   = '0;
                    n_len   = '0;
                    n_inv   = 1'b0;
                end
            end else if (((din.in_byte == CH_DOT) || (din.in_byte == CH_DASH)) &&
                         (r_len < LEN_W'(MAX_CODE_LEN))) begin
                n_pat = {r_pat[MAX_CODE_LEN-2:0], din.in_byte == CH_DASH};
                n_len = LEN_W'(r_len + 1'b1);
            end else begin
                n_inv = 1'b1;
            end
        end
        if (ld_kind == K_DEC) begin
            rom_dec = 1'b1;
            rom_key = {1'b0, mark9[MARK_W-1:0]};
        end
    end

    assign o_rom_req.en    = acc;
    assign o_rom_req.dec   = rom_dec;
    assign o_rom_req.alpha = i_alphabet;
    assign o_rom_req.key   = rom_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat      <= '0;
            r_len      <= '0;
            r_inv      <= 1'b0;
            r_failed   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pat    <= n_pat;
            r_len    <= n_len;
            r_inv    <= n_inv;
            r_failed <= n_failed;
            if (acc) begin
                r_s1_valid <= ld;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_kind    <= ld_kind;
            r_s1_bad     <= r_inv || (r_len > LEN_W'(CODE_W));
            r_s1_nl      <= ld_nl;
            r_s1_setfail <= ld_setfail;
        end
    end

    assign o_job_valid = r_s1_valid;
    assign o_job       = job;

    `MCC_ASSERT_IMP(a_len_bound, 1'b1, r_len <= LEN_W'(MAX_CODE_LEN), "pending length overflow")
    `MCC_ASSERT_NEXT(a_failed_quiet, acc && !din.end_of_text && fail_eff, !r_s1_valid, "item issued while failed")

endmodule

@@ src/mcc_serial.sv @@
// ----------------------------------------------------------------------------
// Morse codec output serializer
// Holds one output job and emits its bytes, one per cycle while the receiver
// does not stall, into the output register.
// ----------------------------------------------------------------------------
`include "morse_code_codec_core_defines.svh"

module mcc_serial (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  mcc_pkg::t_job i_job,
    output logic          o_job_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mcc_pkg::t_out o_out_data
);
    import mcc_pkg::*;

    logic              r_head;
    logic [7:0]        r_hbyte;
    logic              r_herr;
    logic [CNT_W-1:0]  r_cnt;
    logic [CODE_W-1:0] r_bits;
    logic              r_nl;
    logic              r_ov;
    t_out              r_out;

    logic       jv;
    logic       out_load;
    logic       take;
    logic       rest;
    logic [7:0] step_byte;
    logic       step_err;

    assign jv       = r_head || (r_cnt != '0) || r_nl;
    assign out_load = !r_ov || i_out_ready;

    always_comb begin
        priority if (r_head) begin
            step_byte = r_hbyte;
            step_err  = r_herr;
            rest      = (r_cnt != '0) || r_nl;
        end else if (r_cnt != '0) begin
            step_byte = r_bits[CODE_W-1] ? CH_DASH : CH_DOT;
            step_err  = 1'b0;
            rest      = (r_cnt != CNT_W'(1)) || r_nl;
        end else begin
            step_byte = CH_LF;
            step_err  = 1'b0;
            rest      = 1'b0;
        end
    end

    assign o_job_ready = !jv || (out_load && !rest);
    assign take        = i_job_valid && o_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= '0;
            r_nl   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= jv;
            end
            if (take) begin
                r_head <= 1'b1;
                r_cnt  <= i_job.cnt;
                r_nl   <= i_job.nl;
            end else if (jv && out_load) begin
                priority if (r_head) begin
                    r_head <= 1'b0;
                end else if (r_cnt != '0) begin
                    r_cnt <= CNT_W'(r_cnt - 1'b1);
                end else begin
                    r_nl <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hbyte <= i_job.head_byte;
            r_herr  <= i_job.head_err;
            r_bits  <= i_job.bits;
        end else if (jv && out_load && !r_head) begin
            r_bits <= {r_bits[CODE_W-2:0], 1'b0};
        end
        if (out_load && jv) begin
            r_out.out_byte    <= step_byte;
            r_out.last_of_run <= !rest;
            r_out.error       <= step_err;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `MCC_ASSERT_IMP(a_err_alone, r_ov && r_out.error, r_out.last_of_run && r_out.out_byte == CH_NUL, "error result not final")
    `MCC_ASSERT_IMP(a_err_job, r_head && r_herr, r_cnt == '0 && !r_nl, "error job carries more bytes")

endmodule

@@ src/morse_code_codec_core.sv @@
// ----------------------------------------------------------------------------
// Morse code codec core
// Byte-stream Morse encoder and decoder with Latin and Cyrillic alphabets.
// ----------------------------------------------------------------------------
// Usage:
// Input items (a byte and an end-of-text flag) arrive on a valid/ready
// channel; each transfer causes zero to seven result bytes on the output
// valid/ready channel, the final one flagged by last_of_run.
// The first result of an item passes the lookup stage, the serializer's job
// registers and the output register before it is presented. The serializer
// emits one result per cycle while the receiver does not stall, and takes the
// next item's job as it emits the last result of the current one.
// The configuration port writes direction (index 0) and alphabet (index 1)
// with no wait; write only while the core is idle.
// Reset selects encoding with the Latin table, empties the pending symbol and
// clears the error state. When the receiver stalls, the output register holds
// its transfer and the input side keeps accepting until the job stage and the
// lookup stage are both full.
// ----------------------------------------------------------------------------
module morse_code_codec_core #(
    parameter int MAX_CODE_LEN = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mcc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic                              i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mcc_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mcc_pkg::t_out                     o_out_data
);
    import mcc_pkg::*;

    logic      r_direction;
    logic      r_alphabet;
    t_rom_req  rom_req;
    t_rom_word rom_q;
    logic      job_valid;
    logic      job_ready;
    t_job      job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENC;
            r_alphabet  <= ALPHA_LAT;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_DIRECTION) begin
                r_direction <= i_cfg_wdata;
            end
            if (i_cfg_addr == CFG_ALPHABET) begin
                r_alphabet <= i_cfg_wdata;
            end
        end
    end

    mcc_rom u_rom (
        .i_clk (i_clk),
        .i_req (rom_req),
        .o_q   (rom_q)
    );

    mcc_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_direction (r_direction),
        .i_alphabet  (r_alphabet),
        .o_rom_req   (rom_req),
        .i_rom_q     (rom_q),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    mcc_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
